// ===== sv/sync_length_crc_frame_extractor_macros.svh =====
// Assertion macros used by the frame extractor.
`ifndef SYNC_LENGTH_CRC_FRAME_EXTRACTOR_MACROS_SVH
`define SYNC_LENGTH_CRC_FRAME_EXTRACTOR_MACROS_SVH
`define SLCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SLCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/slcf_pkg.sv =====
`timescale 1ns / 1ps
package slcf_pkg;
    localparam int BufferBytes = 64;
    localparam int HeaderBytes = 7;
    localparam int MinFrame = HeaderBytes + 2;
    localparam int PtrW = $clog2(BufferBytes);
    localparam int LvlW = $clog2(BufferBytes + 1);
    localparam logic [7:0] SYNC_HI = 8'hAA;
    localparam logic [7:0] SYNC_LO = 8'h55;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [5:0] PAYLOAD_LIMIT_RESET = 6'd55;

    // One CRC16-CCITT byte update, eight narrow dependent steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction
endpackage

// ===== sv/sync_length_crc_frame_extractor.sv =====
`timescale 1ns / 1ps
// Byte-stream frame synchronizer.
// Input channel: rx_valid/rx_stall with rx_byte, one received byte per item.
// The block stalls the input while it works on a byte: it stores it, then a
// sequencer reading one buffer byte per cycle searches for the sync pair
// AA 55, reads the 32-bit length at bytes 3..6, runs the CRC16 over the
// frame one byte per cycle and compares it with the two trailing bytes.
// Rejected starts drop one byte and rescan. Dropping bytes moves a base
// pointer (the buffer is a circular memory), so nothing is copied.
// Output channel: out_valid/out_stall carrying out_byte, frame_last and the
// three counters as they stood for that frame; each good frame is sent one
// byte per item from sync through CRC, frame_last marking the final byte.
// Each byte passes through the checking states before the next is taken; a rescan
// rereads the buffered bytes for the sync search, the length and the CRC, all
// through the single read port.
// A stalled receiver simply holds the sequencer in its send state.
// Reset empties the buffer, clears the counters and sets the payload limit to 55.
// cfg_valid/cfg_ready write the payload limit (low 6 bits) while idle.
module sync_length_crc_frame_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_last,
    output logic [31:0] good_frames,
    output logic [31:0] crc_error_total,
    output logic [31:0] length_error_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);
`include "sync_length_crc_frame_extractor_macros.svh"

    localparam int PW = slcf_pkg::PtrW;
    localparam int LW = slcf_pkg::LvlW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_HDR   = 9'b000001000,
        S_LENCK = 9'b000010000,
        S_CRC   = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_SEND  = 9'b010000000,
        S_DROP  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] mem [slcf_pkg::BufferBytes];
    logic [7:0] rd_data_reg;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] base_reg, base_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] idx_reg, idx_next;       // offset of the byte being read
    logic [LW-1:0] fsize_reg, fsize_next;
    logic [7:0] prev_reg, prev_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] got_reg, got_next;
    logic [31:0] good_reg, good_next, crce_reg, crce_next, lene_reg, lene_next;
    logic [5:0] maxp_reg;
    logic pend_reg, pend_next;              // a read was issued last cycle
    logic outv_reg, outv_next;
    logic [7:0] ob_reg, ob_next;
    logic ol_reg, ol_next;
    logic [31:0] og_reg, og_next, oc_reg, oc_next, oe_reg, oe_next;
    logic wr_en;

    assign rx_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign wr_en = rx_valid && !rx_stall && (fill_reg < LW'(slcf_pkg::BufferBytes));
    // The read address follows the next pointers, so the registered data matches idx_reg.
    assign rd_addr = base_next + idx_next[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[base_reg + fill_reg[PW-1:0]] <= rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        base_next = base_reg;
        fill_next = fill_reg;
        idx_next = idx_reg;
        fsize_next = fsize_reg;
        prev_next = prev_reg;
        len_next = len_reg;
        crc_next = crc_reg;
        got_next = got_reg;
        good_next = good_reg;
        crce_next = crce_reg;
        lene_next = lene_reg;
        pend_next = 1'b0;
        outv_next = outv_reg;
        ob_next = ob_reg;
        ol_next = ol_reg;
        og_next = og_reg;
        oc_next = oc_reg;
        oe_next = oe_reg;
        if (outv_reg && !out_stall)
        begin
            outv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    if (wr_en)
                    begin
                        fill_next = fill_reg + LW'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                idx_next = '0;
                prev_next = 8'h00;
                if (fill_reg >= LW'(slcf_pkg::MinFrame))
                begin
                    pend_next = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // rd_data_reg holds the byte at offset idx_reg.
                if (pend_reg)
                begin
                    if (idx_reg != '0 && prev_reg == slcf_pkg::SYNC_HI
                        && rd_data_reg == slcf_pkg::SYNC_LO)
                    begin
                        base_next = base_reg + PW'(idx_reg - LW'(1));
                        fill_next = fill_reg - (idx_reg - LW'(1));
                        idx_next = LW'(3);
                        len_next = '0;
                        state_next = S_HDR;
                    end
                    else if (idx_reg + LW'(1) >= fill_reg)
                    begin
                        if (rd_data_reg == slcf_pkg::SYNC_HI)
                        begin
                            base_next = base_reg + PW'(idx_reg);
                            fill_next = LW'(1);
                        end
                        else
                        begin
                            fill_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        prev_next = rd_data_reg;
                        idx_next = idx_reg + LW'(1);
                        pend_next = 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b1;
                end
            end
            S_HDR:
            begin
                if (fill_reg < LW'(slcf_pkg::MinFrame))
                begin
                    state_next = S_IDLE;
                end
                else if (pend_reg)
                begin
                    len_next = {len_reg[23:0], rd_data_reg};
                    if (idx_reg == LW'(6))
                    begin
                        state_next = S_LENCK;
                    end
                    else
                    begin
                        idx_next = idx_reg + LW'(1);
                        pend_next = 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b1;
                end
            end
            S_LENCK:
            begin
                if (len_reg > {26'd0, maxp_reg}
                    || len_reg > 32'(slcf_pkg::BufferBytes - slcf_pkg::MinFrame))
                begin
                    lene_next = lene_reg + 32'd1;
                    state_next = S_DROP;
                end
                else
                begin
                    fsize_next = LW'(len_reg) + LW'(slcf_pkg::MinFrame);
                    if (fill_reg < LW'(len_reg) + LW'(slcf_pkg::MinFrame))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = '0;
                        crc_next = slcf_pkg::CRC_INIT;
                        pend_next = 1'b1;
                        state_next = S_CRC;
                    end
                end
            end
            S_CRC:
            begin
                if (pend_reg)
                begin
                    if (idx_reg + LW'(2) < fsize_reg)
                    begin
                        crc_next = slcf_pkg::crc_byte(crc_reg, rd_data_reg);
                    end
                    else
                    begin
                        got_next = {got_reg[7:0], rd_data_reg};
                    end
                    if (idx_reg + LW'(1) == fsize_reg)
                    begin
                        state_next = S_CMP;
                    end
                    else
                    begin
                        idx_next = idx_reg + LW'(1);
                        pend_next = 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b1;
                end
            end
            S_CMP:
            begin
                if (got_reg != crc_reg)
                begin
                    crce_next = crce_reg + 32'd1;
                    state_next = S_DROP;
                end
                else
                begin
                    good_next = good_reg + 32'd1;
                    idx_next = '0;
                    pend_next = 1'b1;
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (pend_reg)
                begin
                    if (!outv_next)
                    begin
                        outv_next = 1'b1;
                        ob_next = rd_data_reg;
                        ol_next = (idx_reg + LW'(1) == fsize_reg);
                        og_next = good_reg;
                        oc_next = crce_reg;
                        oe_next = lene_reg;
                        if (idx_reg + LW'(1) == fsize_reg)
                        begin
                            base_next = base_reg + PW'(fsize_reg);
                            fill_next = fill_reg - fsize_reg;
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            idx_next = idx_reg + LW'(1);
                            pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pend_next = 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b1;
                end
            end
            S_DROP:
            begin
                base_next = base_reg + PW'(1);
                fill_next = fill_reg - LW'(1);
                state_next = S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg <= '0;
            fill_reg <= '0;
            good_reg <= '0;
            crce_reg <= '0;
            lene_reg <= '0;
            maxp_reg <= slcf_pkg::PAYLOAD_LIMIT_RESET;
            pend_reg <= 1'b0;
            outv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg <= base_next;
            fill_reg <= fill_next;
            good_reg <= good_next;
            crce_reg <= crce_next;
            lene_reg <= lene_next;
            pend_reg <= pend_next;
            outv_reg <= outv_next;
            if (cfg_valid && cfg_ready)
            begin
                maxp_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        fsize_reg <= fsize_next;
        prev_reg <= prev_next;
        len_reg <= len_next;
        crc_reg <= crc_next;
        got_reg <= got_next;
        ob_reg <= ob_next;
        ol_reg <= ol_next;
        og_reg <= og_next;
        oc_reg <= oc_next;
        oe_reg <= oe_next;
    end

    assign out_valid = outv_reg;
    assign out_byte = ob_reg;
    assign frame_last = ol_reg;
    assign good_frames = og_reg;
    assign crc_error_total = oc_reg;
    assign length_error_total = oe_reg;

    `SLCF_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= LW'(slcf_pkg::BufferBytes))
    `SLCF_ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `SLCF_ASSERT_NEXT(a_good_step, clk, rst_n, state_reg == S_CMP && got_reg == crc_reg,
        good_reg == $past(good_reg) + 32'd1)
    `SLCF_ASSERT_NEXT(a_drop, clk, rst_n, state_reg == S_DROP,
        fill_reg == $past(fill_reg) - LW'(1))
endmodule
